// File: rtl/core/gcb_pkg.sv
// Shared types, class codes and decode function for the grapheme cluster break block.
package gcb_pkg;

  // Width of the byte offset counter unless the top level overrides it
  localparam int unsigned GcbOffsetWidthDef = 32;
  // Width of the reported offset field
  localparam int unsigned GcbOutOffsetWidth = 32;
  // Words held between the front and back parts
  localparam int unsigned GcbQueueDepth = 4;
  localparam int unsigned GcbQueuePtrW  = $clog2(GcbQueueDepth);
  localparam int unsigned GcbQueueCntW  = $clog2(GcbQueueDepth + 1);

  // Break class codes as they arrive on the input
  typedef enum logic [4:0] {
    CLS_OTHER      = 5'd0,
    CLS_CR         = 5'd1,
    CLS_LF         = 5'd2,
    CLS_CONTROL    = 5'd3,
    CLS_L          = 5'd4,
    CLS_V          = 5'd5,
    CLS_LV         = 5'd6,
    CLS_LVT        = 5'd7,
    CLS_T          = 5'd8,
    CLS_EXTEND     = 5'd9,
    CLS_ZWJ        = 5'd10,
    CLS_INCB_EXT   = 5'd11,
    CLS_INCB_LINK  = 5'd12,
    CLS_SPACING    = 5'd13,
    CLS_PREPEND    = 5'd14,
    CLS_CONSONANT  = 5'd15,
    CLS_RI         = 5'd16
  } gcb_class_e;

  // Decoded class: one flag per property the rules look at
  typedef struct packed {
    logic cr;
    logic lf;
    logic ctl;       // CR, LF or control
    logic hl_l;
    logic hl_v;
    logic hl_lv;
    logic hl_lvt;
    logic hl_t;
    logic ext_any;   // extend, ZWJ, InCB extend or InCB linker
    logic zwj;
    logic incb_ext;
    logic link;
    logic spacing;
    logic prepend;
    logic cons;
    logic ri;
  } cls_t;

  // One classified word travelling through the queue
  typedef struct packed {
    cls_t       cls;
    logic       ep;
    logic [2:0] bytes;
    logic       start;
  } item_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Turn a raw class code into flags; unknown codes decode as other
  function automatic cls_t gcb_decode(logic [4:0] code);
    cls_t f;
    f = '0;
    unique case (code)
      CLS_CR:        begin f.cr = 1'b1; f.ctl = 1'b1; end
      CLS_LF:        begin f.lf = 1'b1; f.ctl = 1'b1; end
      CLS_CONTROL:   f.ctl = 1'b1;
      CLS_L:         f.hl_l = 1'b1;
      CLS_V:         f.hl_v = 1'b1;
      CLS_LV:        f.hl_lv = 1'b1;
      CLS_LVT:       f.hl_lvt = 1'b1;
      CLS_T:         f.hl_t = 1'b1;
      CLS_EXTEND:    f.ext_any = 1'b1;
      CLS_ZWJ:       begin f.ext_any = 1'b1; f.zwj = 1'b1; end
      CLS_INCB_EXT:  begin f.ext_any = 1'b1; f.incb_ext = 1'b1; end
      CLS_INCB_LINK: begin f.ext_any = 1'b1; f.link = 1'b1; end
      CLS_SPACING:   f.spacing = 1'b1;
      CLS_PREPEND:   f.prepend = 1'b1;
      CLS_CONSONANT: f.cons = 1'b1;
      CLS_RI:        f.ri = 1'b1;
      default:       f = '0;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/core/gcb_front.sv
// Front part: accepts code point words and classifies them for the queue.
module gcb_front import gcb_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [4:0] gcb_class_i,
  input  logic       ext_pict_i,
  input  logic [2:0] cp_bytes_i,
  input  logic       text_start_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output item_t      push_item_o
);

  // Take a word whenever the queue has room
  assign in_ready_o = ~q_status_i.full;
  assign push_o     = in_valid_i & ~q_status_i.full;

  // Decode the class into flags ahead of the rule logic
  always_comb begin
    push_item_o.cls   = gcb_decode(gcb_class_i);
    push_item_o.ep    = ext_pict_i;
    push_item_o.bytes = cp_bytes_i;
    push_item_o.start = text_start_i;
  end

endmodule

// File: rtl/core/gcb_queue.sv
// Short register queue between the front and back parts.
module gcb_queue import gcb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  item_t     push_item_i,
  input  logic      pop_i,
  output item_t     head_o,
  output q_status_t status_o
);

  item_t                    mem_q [GcbQueueDepth];
  logic [GcbQueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [GcbQueueCntW-1:0]  count_q;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == GcbQueueCntW'(GcbQueueDepth));
  assign head_o         = mem_q[rd_ptr_q];

  // Store words; payload needs no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == GcbQueuePtrW'(GcbQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == GcbQueuePtrW'(GcbQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/gcb_back.sv
// Back part: applies the break rules, keeps the context and drives the result register.
module gcb_back import gcb_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = GcbOffsetWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  item_t                        head_i,
  input  q_status_t                    q_status_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         break_before_o,
  output logic [GcbOutOffsetWidth-1:0] start_offset_o
);

  cls_t                    last_q, last_d;
  logic                    ri_odd_q, ri_odd_d;
  logic                    aj_q, aj_d;         // previous word was a ZWJ
  logic                    pbj_q, pbj_d;       // pictographic before the joiner
  logic                    cb_q, cb_d;         // conjunct consonant base seen
  logic                    ls_q, ls_d;         // conjunct linker seen
  logic [OFFSET_WIDTH-1:0] off_q, off_d;
  logic                    out_valid_q;
  logic                    brk_q, brk_d;
  logic [GcbOutOffsetWidth-1:0] soff_q;

  cls_t                    c;
  cls_t                    p;
  logic                    rules_brk;
  logic [OFFSET_WIDTH-1:0] base;
  logic [OFFSET_WIDTH:0]   sum;

  assign c = head_i.cls;
  assign p = last_q;

  // Pop when a word waits and the result register is free or draining
  assign pop_o = ~q_status_i.empty & (~out_valid_q | out_ready_i);

  // Pair rules GB3 to GB13 in order
  always_comb begin
    priority if (p.cr && c.lf)                                     rules_brk = 1'b0;
    else if (p.ctl || c.ctl)                                       rules_brk = 1'b1;
    else if (p.hl_l && (c.hl_l || c.hl_v || c.hl_lv || c.hl_lvt))  rules_brk = 1'b0;
    else if ((p.hl_lv || p.hl_v) && (c.hl_v || c.hl_t))            rules_brk = 1'b0;
    else if ((p.hl_lvt || p.hl_t) && c.hl_t)                       rules_brk = 1'b0;
    else if (c.ext_any)                                            rules_brk = 1'b0;
    else if (c.spacing)                                            rules_brk = 1'b0;
    else if (p.prepend)                                            rules_brk = 1'b0;
    else if (c.cons && cb_q && ls_q)                               rules_brk = 1'b0;
    else if (p.ri && c.ri)                                         rules_brk = ~ri_odd_q;
    else                                                           rules_brk = 1'b1;
  end

  // Context update for the word at the head
  always_comb begin
    last_d   = last_q;
    ri_odd_d = ri_odd_q;
    aj_d     = aj_q;
    pbj_d    = pbj_q;
    cb_d     = cb_q;
    ls_d     = ls_q;
    brk_d    = 1'b1;

    if (head_i.start || (!(aj_q && pbj_q && head_i.ep) && rules_brk)) begin
      // Reseed from this word alone
      brk_d    = 1'b1;
      last_d   = c;
      ri_odd_d = c.ri;
      aj_d     = c.zwj;
      pbj_d    = head_i.ep;
      cb_d     = c.cons;
      ls_d     = 1'b0;
    end else begin
      brk_d  = 1'b0;
      last_d = c;
      aj_d   = c.zwj;
      if (aj_q && pbj_q && head_i.ep) begin
        // Emoji ZWJ sequence continues
        aj_d     = 1'b0;
        pbj_d    = 1'b1;
        ri_odd_d = 1'b0;
      end else begin
        ri_odd_d = c.ri ? ~ri_odd_q : 1'b0;
        if (head_i.ep) begin
          pbj_d = 1'b1;
        end else if (!c.ext_any) begin
          pbj_d = 1'b0;
        end
      end
      // Conjunct chain tracking
      if (c.link) begin
        ls_d = 1'b1;
      end else if (c.cons) begin
        cb_d = 1'b1;
        ls_d = 1'b0;
      end else if (!c.incb_ext && !c.zwj) begin
        cb_d = 1'b0;
        ls_d = 1'b0;
      end
    end
  end

  // Saturating byte offset
  assign base = head_i.start ? '0 : off_q;
  assign sum  = {1'b0, base} + (OFFSET_WIDTH + 1)'(head_i.bytes);
  assign off_d = sum[OFFSET_WIDTH] ? '1 : sum[OFFSET_WIDTH-1:0];

  // Hold context and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      ri_odd_q    <= 1'b0;
      aj_q        <= 1'b0;
      pbj_q       <= 1'b0;
      cb_q        <= 1'b0;
      ls_q        <= 1'b0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        last_q      <= last_d;
        ri_odd_q    <= ri_odd_d;
        aj_q        <= aj_d;
        pbj_q       <= pbj_d;
        cb_q        <= cb_d;
        ls_q        <= ls_d;
        off_q       <= off_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      brk_q  <= brk_d;
      soff_q <= GcbOutOffsetWidth'(base);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign break_before_o = brk_q;
  assign start_offset_o = soff_q;

endmodule

// File: rtl/core/grapheme_cluster_break_top.sv
// Top level of the grapheme cluster break detector.
// Takes one decoded code point word per cycle while the queue is not full (class,
// pictographic flag, UTF-8 length, start-of-text mark) and returns, for each,
// whether a grapheme cluster boundary lies before it and its byte offset in the
// text. An accepted word is registered in the queue and then in the output
// register before it is valid on the output; the back part evaluates the rules
// for the queue head combinationally. A four-word queue sits between the
// classifying front part and the rule back part, and the result sits in an
// output register, so input is taken while a result waits until four words are
// queued. The offset counter is OFFSET_WIDTH bits wide, saturates at its
// all-ones value and is reported through its low 32 bits.
module grapheme_cluster_break_top import gcb_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = GcbOffsetWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [4:0]                   gcb_class_i,
  input  logic                         ext_pict_i,
  input  logic [2:0]                   cp_bytes_i,
  input  logic                         text_start_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         break_before_o,
  output logic [GcbOutOffsetWidth-1:0] start_offset_o
);

  q_status_t q_status;
  logic      push;
  logic      pop;
  item_t     push_item;
  item_t     head_item;

  // Classify and push
  gcb_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .gcb_class_i  (gcb_class_i),
    .ext_pict_i   (ext_pict_i),
    .cp_bytes_i   (cp_bytes_i),
    .text_start_i (text_start_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  // Decouple the two sides
  gcb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .status_o    (q_status)
  );

  // Apply rules and drive results
  gcb_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_item),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .break_before_o (break_before_o),
    .start_offset_o (start_offset_o)
  );

  // Queue cannot read as both empty and full
  a_q_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.empty && q_status.full))
    else $error("queue reports empty and full together");

  // A waiting word reaches the output when the result register is free
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_status.empty && (!out_valid_o || out_ready_i)) |=> out_valid_o)
    else $error("queued word did not reach the output");

  // After a word is accepted, the queue is not empty or the output is valid next cycle
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!q_status.empty || out_valid_o))
    else $error("accepted word was lost");

endmodule

// File: tb/gcb_break_checker.sv
// Checker for the grapheme cluster break block: predicts each result word and compares it.
`timescale 1ns / 100ps

module gcb_break_checker import gcb_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = GcbOffsetWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [4:0]                   gcb_class_i,
  input  logic                         ext_pict_i,
  input  logic [2:0]                   cp_bytes_i,
  input  logic                         text_start_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         break_before_i,
  input  logic [GcbOutOffsetWidth-1:0] start_offset_i,
  output int                           mismatch_count_o,
  output int                           pending_count_o,
  output int                           checked_count_o,
  output int                           break_count_o
);

  // All ones at the counter width; a shift by 64 gives zero, so 64 wraps to all ones too
  localparam logic [63:0] OffsetMax = (64'd1 << OFFSET_WIDTH) - 64'd1;

  typedef struct packed {
    logic                         brk;
    logic [GcbOutOffsetWidth-1:0] offset;
  } boundary_t;

  boundary_t boundary_q[$];

  // Context of the cluster being built
  logic [4:0]  prev_cls      = CLS_OTHER;
  logic        ri_parity     = 1'b0;
  logic        joiner_seen   = 1'b0;
  logic        pict_chain    = 1'b0;
  logic        cons_base     = 1'b0;
  logic        link_seen     = 1'b0;
  logic [63:0] text_offset   = '0;

  function automatic logic is_control(logic [4:0] c);
    return c == CLS_CR || c == CLS_LF || c == CLS_CONTROL;
  endfunction

  function automatic logic is_extend(logic [4:0] c);
    return c == CLS_EXTEND || c == CLS_ZWJ || c == CLS_INCB_EXT || c == CLS_INCB_LINK;
  endfunction

  // Pair rules, tried in order; unknown codes match nothing and so act as other
  function automatic logic pair_breaks(logic [4:0] p, logic [4:0] c);
    if (p == CLS_CR && c == CLS_LF) return 1'b0;
    if (is_control(p) || is_control(c)) return 1'b1;
    if (p == CLS_L && (c == CLS_L || c == CLS_V || c == CLS_LV || c == CLS_LVT)) return 1'b0;
    if ((p == CLS_LV || p == CLS_V) && (c == CLS_V || c == CLS_T)) return 1'b0;
    if ((p == CLS_LVT || p == CLS_T) && c == CLS_T) return 1'b0;
    if (is_extend(c)) return 1'b0;
    if (c == CLS_SPACING) return 1'b0;
    if (p == CLS_PREPEND) return 1'b0;
    if (c == CLS_CONSONANT && cons_base && link_seen) return 1'b0;
    if (p == CLS_RI && c == CLS_RI) return !ri_parity;
    return 1'b1;
  endfunction

  // Restart the context from one code point
  function automatic void reseed(logic [4:0] c, logic ep);
    prev_cls    = c;
    ri_parity   = (c == CLS_RI);
    joiner_seen = (c == CLS_ZWJ);
    pict_chain  = ep;
    cons_base   = (c == CLS_CONSONANT);
    link_seen   = 1'b0;
  endfunction

  // Track the consonant-linker-consonant chain
  function automatic void track_conjunct(logic [4:0] c);
    if (c == CLS_INCB_LINK) begin
      link_seen = 1'b1;
    end else if (c == CLS_CONSONANT) begin
      cons_base = 1'b1;
      link_seen = 1'b0;
    end else if (c != CLS_INCB_EXT && c != CLS_ZWJ) begin
      cons_base = 1'b0;
      link_seen = 1'b0;
    end
  endfunction

  // Work out the result for one input word and advance the context
  function automatic boundary_t predict_boundary(logic [4:0] c, logic ep, logic [2:0] nbytes,
                                                 logic start);
    boundary_t b;
    if (start) begin
      text_offset = '0;
      b.brk = 1'b1;
      reseed(c, ep);
    end else if (joiner_seen && pict_chain && ep) begin
      // Emoji joined after a ZWJ stays in the cluster
      b.brk       = 1'b0;
      prev_cls    = c;
      joiner_seen = 1'b0;
      pict_chain  = 1'b1;
      ri_parity   = 1'b0;
      track_conjunct(c);
    end else begin
      b.brk = pair_breaks(prev_cls, c);
      if (b.brk) begin
        reseed(c, ep);
      end else begin
        ri_parity = (c == CLS_RI) ? !ri_parity : 1'b0;
        if (ep) pict_chain = 1'b1;
        else if (!is_extend(c)) pict_chain = 1'b0;
        joiner_seen = (c == CLS_ZWJ);
        track_conjunct(c);
        prev_cls = c;
      end
    end
    b.offset = text_offset[GcbOutOffsetWidth-1:0];
    // Saturate the offset at the counter's all-ones value
    if (OffsetMax - text_offset < 64'(nbytes)) text_offset = OffsetMax;
    else text_offset = text_offset + 64'(nbytes);
    return b;
  endfunction

  // Compare accepted results, then queue the prediction for an accepted input word
  always @(posedge clk_i or negedge rst_ni) begin : watch
    boundary_t got;
    boundary_t want;
    if (!rst_ni) begin
      boundary_q.delete();
      reseed(CLS_OTHER, 1'b0);
      text_offset      = '0;
      mismatch_count_o = 0;
      pending_count_o  = 0;
      checked_count_o  = 0;
      break_count_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.brk    = break_before_i;
        got.offset = start_offset_i;
        checked_count_o = checked_count_o + 1;
        if (got.brk) break_count_o = break_count_o + 1;
        if (boundary_q.size() == 0) begin
          mismatch_count_o = mismatch_count_o + 1;
          $display("%0t: result word expected none actual break %0b offset %0d", $time,
                   got.brk, got.offset);
        end else begin
          want = boundary_q.pop_front();
          if (got.brk !== want.brk) begin
            mismatch_count_o = mismatch_count_o + 1;
            $display("%0t: break_before expected %0b actual %0b", $time, want.brk, got.brk);
          end
          if (got.offset !== want.offset) begin
            mismatch_count_o = mismatch_count_o + 1;
            $display("%0t: start_offset expected %0d actual %0d", $time,
                     want.offset, got.offset);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        boundary_q.push_back(predict_boundary(gcb_class_i, ext_pict_i, cp_bytes_i,
                                              text_start_i));
      pending_count_o = boundary_q.size();
    end
  end

endmodule

// File: tb/grapheme_cluster_break_top_tb.sv
// Testbench top for the grapheme cluster break block: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module grapheme_cluster_break_top_tb;
  import gcb_pkg::*;

  // Counter narrower than the default to exercise the width parameter
  localparam int unsigned OffsetW      = 16;
  localparam int          RandomWords  = 500;
  localparam int          FinalWords   = 60;
  localparam int          StallLimit   = 1000;
  localparam int          DrainCycles  = 8;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [4:0]                   gcb_class_i;
  logic                         ext_pict_i;
  logic [2:0]                   cp_bytes_i;
  logic                         text_start_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic                         break_before_o;
  logic [GcbOutOffsetWidth-1:0] start_offset_o;

  int   mismatch_count;
  int   pending_count;
  int   checked_count;
  int   break_count;
  int   words_sent = 0;
  logic idle_on    = 1'b1;

  grapheme_cluster_break_top #(
    .OFFSET_WIDTH(OffsetW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .gcb_class_i   (gcb_class_i),
    .ext_pict_i    (ext_pict_i),
    .cp_bytes_i    (cp_bytes_i),
    .text_start_i  (text_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .break_before_o(break_before_o),
    .start_offset_o(start_offset_o)
  );

  gcb_break_checker #(
    .OFFSET_WIDTH(OffsetW)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .gcb_class_i     (gcb_class_i),
    .ext_pict_i      (ext_pict_i),
    .cp_bytes_i      (cp_bytes_i),
    .text_start_i    (text_start_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .break_before_i  (break_before_o),
    .start_offset_i  (start_offset_o),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count),
    .checked_count_o (checked_count),
    .break_count_o   (break_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side in bursts while idling is on, otherwise stay ready
  initial begin
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // End the run if no word moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet = quiet + 1;
      if (quiet >= StallLimit) begin
        $display("Watchdog: no word moved for %0d cycles", StallLimit);
        $display("FAIL");
        $finish;
      end
    end
  end

  // Offer one word and hold it until taken; an optional gap goes first
  task automatic send_word(logic [4:0] cls, logic ep, logic [2:0] nbytes, logic start);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    gcb_class_i  <= cls;
    ext_pict_i   <= ep;
    cp_bytes_i   <= nbytes;
    text_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent = words_sent + 1;
  endtask

  // Mostly real UTF-8 lengths, now and then any 3-bit value
  function automatic logic [2:0] pick_bytes();
    if ($urandom_range(0, 7) == 0) return 3'($urandom_range(0, 7));
    return 3'($urandom_range(1, 4));
  endfunction

  function automatic logic pick_start();
    return $urandom_range(0, 11) == 0;
  endfunction

  // One mark that keeps a conjunct chain open
  function automatic logic [4:0] pick_joiner();
    case ($urandom_range(0, 2))
      0:       return CLS_INCB_EXT;
      1:       return CLS_ZWJ;
      default: return CLS_INCB_LINK;
    endcase
  endfunction

  // One mark of the Extend family or a spacing mark
  function automatic logic [4:0] pick_mark();
    case ($urandom_range(0, 3))
      0:       return CLS_EXTEND;
      1:       return CLS_INCB_EXT;
      2:       return CLS_INCB_LINK;
      default: return CLS_SPACING;
    endcase
  endfunction

  // Send one mostly well-formed cluster with random content, or a noise word
  task automatic send_cluster();
    int kind;
    kind = $urandom_range(0, 7);
    case (kind)
      0: begin
        send_word(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                  3'($urandom_range(0, 7)), $urandom_range(0, 15) == 0);
      end
      1: begin
        // Hangul syllable: leading jamo, a vowel part, trailing jamo
        send_word(CLS_L, 1'b0, pick_bytes(), pick_start());
        repeat ($urandom_range(0, 1)) send_word(CLS_L, 1'b0, pick_bytes(), 1'b0);
        case ($urandom_range(0, 2))
          0:       send_word(CLS_V, 1'b0, pick_bytes(), 1'b0);
          1:       send_word(CLS_LV, 1'b0, pick_bytes(), 1'b0);
          default: send_word(CLS_LVT, 1'b0, pick_bytes(), 1'b0);
        endcase
        repeat ($urandom_range(0, 1)) send_word(CLS_V, 1'b0, pick_bytes(), 1'b0);
        repeat ($urandom_range(0, 2)) send_word(CLS_T, 1'b0, pick_bytes(), 1'b0);
      end
      2: begin
        // Conjunct: consonant, marks with a linker, consonant; a plain extend may end it
        send_word(CLS_CONSONANT, 1'b0, pick_bytes(), pick_start());
        repeat ($urandom_range(0, 2)) send_word(pick_joiner(), 1'b0, pick_bytes(), 1'b0);
        if ($urandom_range(0, 4) == 0) send_word(CLS_EXTEND, 1'b0, pick_bytes(), 1'b0);
        send_word(CLS_INCB_LINK, 1'b0, pick_bytes(), 1'b0);
        repeat ($urandom_range(0, 2)) send_word(pick_joiner(), 1'b0, pick_bytes(), 1'b0);
        send_word(CLS_CONSONANT, 1'b0, pick_bytes(), 1'b0);
        repeat ($urandom_range(0, 1)) send_word(pick_joiner(), 1'b0, pick_bytes(), 1'b0);
      end
      3: begin
        // Emoji ZWJ sequence, sometimes with the joiner or the pictograph missing
        send_word(CLS_OTHER, 1'b1, 3'd4, pick_start());
        repeat ($urandom_range(1, 3)) begin
          repeat ($urandom_range(0, 2)) send_word(pick_mark(), 1'b0, pick_bytes(), 1'b0);
          if ($urandom_range(0, 4) != 0) send_word(CLS_ZWJ, 1'b0, 3'd3, 1'b0);
          send_word($urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 16)) : CLS_OTHER,
                    $urandom_range(0, 4) != 0, 3'd4, 1'b0);
        end
      end
      4: begin
        repeat ($urandom_range(1, 5)) send_word(CLS_RI, 1'b0, 3'd4, 1'b0);
      end
      5: begin
        case ($urandom_range(0, 2))
          0: begin
            send_word(CLS_CR, 1'b0, 3'd1, pick_start());
            send_word(CLS_LF, 1'b0, 3'd1, 1'b0);
          end
          1:       send_word(CLS_CR, 1'b0, 3'd1, 1'b0);
          default: send_word($urandom_range(0, 1) ? CLS_LF : CLS_CONTROL, 1'b0, 3'd1, 1'b0);
        endcase
      end
      6: begin
        repeat ($urandom_range(1, 2)) send_word(CLS_PREPEND, 1'b0, pick_bytes(), pick_start());
        send_word(5'($urandom_range(0, 16)), 1'($urandom_range(0, 1)), pick_bytes(), 1'b0);
        repeat ($urandom_range(0, 2)) send_word(pick_mark(), 1'b0, pick_bytes(), 1'b0);
      end
      default: begin
        send_word(5'($urandom_range(0, 16)), 1'($urandom_range(0, 1)), pick_bytes(),
                  pick_start());
        repeat ($urandom_range(0, 3))
          send_word(5'($urandom_range(0, 16)), 1'($urandom_range(0, 1)), pick_bytes(), 1'b0);
      end
    endcase
  endtask

  initial begin
    int target;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    gcb_class_i  = CLS_OTHER;
    ext_pict_i   = 1'b0;
    cp_bytes_i   = 3'd1;
    text_start_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no start mark after reset, then each rule and its edge cases
    send_word(CLS_LF, 1'b0, 3'd1, 1'b0);
    send_word(CLS_CR, 1'b0, 3'd1, 1'b0);
    send_word(CLS_LF, 1'b0, 3'd1, 1'b0);
    send_word(CLS_CONTROL, 1'b0, 3'd0, 1'b0);
    send_word(CLS_L, 1'b0, 3'd3, 1'b1);
    send_word(CLS_V, 1'b0, 3'd3, 1'b0);
    send_word(CLS_T, 1'b0, 3'd3, 1'b0);
    send_word(CLS_LV, 1'b0, 3'd3, 1'b0);
    send_word(CLS_T, 1'b0, 3'd3, 1'b0);
    // Conjunct joined through InCB extend, linker and ZWJ
    send_word(CLS_CONSONANT, 1'b0, 3'd3, 1'b0);
    send_word(CLS_INCB_EXT, 1'b0, 3'd3, 1'b0);
    send_word(CLS_INCB_LINK, 1'b0, 3'd3, 1'b0);
    send_word(CLS_ZWJ, 1'b0, 3'd3, 1'b0);
    send_word(CLS_CONSONANT, 1'b0, 3'd3, 1'b0);
    // Plain extend ends the conjunct chain
    send_word(CLS_EXTEND, 1'b0, 3'd2, 1'b0);
    send_word(CLS_INCB_LINK, 1'b0, 3'd3, 1'b0);
    send_word(CLS_CONSONANT, 1'b0, 3'd3, 1'b0);
    // Emoji chain: an InCB linker before the ZWJ is transparent
    send_word(CLS_OTHER, 1'b1, 3'd4, 1'b1);
    send_word(CLS_INCB_LINK, 1'b0, 3'd3, 1'b0);
    send_word(CLS_ZWJ, 1'b0, 3'd3, 1'b0);
    send_word(CLS_OTHER, 1'b1, 3'd4, 1'b0);
    send_word(CLS_RI, 1'b0, 3'd4, 1'b0);
    send_word(CLS_RI, 1'b0, 3'd4, 1'b0);
    send_word(CLS_RI, 1'b0, 3'd4, 1'b0);
    // Prepend, unknown codes and odd byte lengths
    send_word(CLS_PREPEND, 1'b0, 3'd5, 1'b0);
    send_word(5'd31, 1'b0, 3'd6, 1'b0);
    send_word(CLS_SPACING, 1'b0, 3'd7, 1'b0);
    send_word(5'd17, 1'b1, 3'd7, 1'b1);
    send_word(CLS_LVT, 1'b0, 3'd2, 1'b0);

    // Random clusters with idling switched on and off in stretches
    target = words_sent + RandomWords;
    while (words_sent < target) begin
      if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
      send_cluster();
    end

    // Final part without idling: two texts of back-to-back words
    idle_on = 1'b0;
    send_word(CLS_OTHER, 1'b0, 3'd7, 1'b1);
    repeat (FinalWords)
      send_word(5'($urandom_range(0, 16)), 1'($urandom_range(0, 1)), pick_bytes(), 1'b0);
    send_word(CLS_OTHER, 1'b0, 3'd2, 1'b1);
    send_word(CLS_EXTEND, 1'b0, 3'd1, 1'b0);
    in_valid_i <= 1'b0;

    // Drain, then allow for the pipeline latency
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words, checked %0d results with %0d cluster breaks", words_sent,
             checked_count, break_count);
    $display("Covered every break class, unknown codes, odd lengths and a %0d-bit offset",
             OffsetW);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
